// ===== hdl/lcef_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lcef_pkg;

  localparam int unsigned PosW   = 32;
  localparam int unsigned MagW   = 16;
  localparam int unsigned GainW  = 16;
  localparam int unsigned LevelW = 17;
  localparam int unsigned VoltW  = 8;
  localparam int unsigned CsW    = 29;
  localparam int unsigned PctW   = 7;
  localparam int unsigned ScaleW = 15;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 17;

  localparam logic [CfgIdxW-1:0] CFG_GAIN      = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_LEVEL = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DECAY     = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_VOLTAGE   = 2'd3;

  localparam logic [GainW-1:0]  GAIN_RESET  = 16'd256;
  localparam logic [LevelW-1:0] MIN_RESET   = 17'd0;
  localparam logic [LevelW-1:0] DECAY_RESET = 17'd66;
  // 100 * default voltage of 220
  localparam logic [ScaleW-1:0] SCALE_RESET = 15'd22000;
  localparam logic [6:0]        PERCENT     = 7'd100;

  localparam logic [LevelW-1:0] LEVEL_ONE = 17'h10000;

  // floor(x / 10) = (x * CsRecip) >> 35 for any 32-bit x
  localparam logic [31:0] CS_RECIP = 32'hCCCCCCCD;
  localparam int unsigned CsShift  = 35;
  // floor(y / 220) = (y * VoltRecip) >> 24 for y up to 25500
  localparam logic [16:0] VOLT_RECIP = 17'd76261;
  localparam int unsigned VoltShift  = 24;

  typedef struct packed {
    logic load;
    logic mul;
    logic lvl;
    logic pct;
    logic quo;
    logic fin;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/light_channel_envelope_follower.sv =====
// Envelope follower for one light channel: peak hold with linear decay.
// Each word passes the load, multiply, level, percent, quotient and finish
// states. in_stall_o holds off new words until the sequencer is back in idle;
// the output register lets the next word start while a result waits.
// Reset: asynchronous, active low; configuration and envelope state return to
// their defaults and no previous frame is held.
`timescale 1ns / 1ps
`default_nettype none

module light_channel_envelope_follower (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [lcef_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [lcef_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [lcef_pkg::PosW-1:0]     position_ms_i,
  input  wire logic [lcef_pkg::MagW-1:0]     magnitude_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [lcef_pkg::CsW-1:0]      start_cs_o,
  output logic      [lcef_pkg::CsW-1:0]      end_cs_o,
  output logic      [lcef_pkg::PctW-1:0]     light_level_o
);

  lcef_pkg::cmd_t cmd;

  lcef_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  lcef_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .position_ms_i (position_ms_i),
    .magnitude_i   (magnitude_i),
    .cmd_i         (cmd),
    .start_cs_o    (start_cs_o),
    .end_cs_o      (end_cs_o),
    .light_level_o (light_level_o)
  );

endmodule

`default_nettype wire

// ===== hdl/lcef_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lcef_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output lcef_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LVL,
    ST_PCT,
    ST_QUO,
    ST_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o      = '0;
    cmd_o.load = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.mul  = (state_q == ST_MUL);
    cmd_o.lvl  = (state_q == ST_LVL);
    cmd_o.pct  = (state_q == ST_PCT);
    cmd_o.quo  = (state_q == ST_QUO);
    cmd_o.fin  = (state_q == ST_FIN) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.fin) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_MUL;
        end
        ST_MUL:  state_q <= ST_LVL;
        ST_LVL:  state_q <= ST_PCT;
        ST_PCT:  state_q <= ST_QUO;
        ST_QUO:  state_q <= ST_FIN;
        ST_FIN: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/lcef_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lcef_datapath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [lcef_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [lcef_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wire logic [lcef_pkg::PosW-1:0]         position_ms_i,
  input  wire logic [lcef_pkg::MagW-1:0]         magnitude_i,
  input  wire lcef_pkg::cmd_t                    cmd_i,
  output logic      [lcef_pkg::CsW-1:0]          start_cs_o,
  output logic      [lcef_pkg::CsW-1:0]          end_cs_o,
  output logic      [lcef_pkg::PctW-1:0]         light_level_o
);

  // configuration
  logic [lcef_pkg::GainW-1:0]  gain_q;
  logic [lcef_pkg::LevelW-1:0] min_q;
  logic [lcef_pkg::LevelW-1:0] decay_q;
  logic [lcef_pkg::ScaleW-1:0] scale_q;

  // envelope state
  logic                        have_prev_q;
  logic [lcef_pkg::PosW-1:0]   prev_time_q;
  logic [lcef_pkg::MagW-1:0]   prev_mag_q;
  logic [lcef_pkg::CsW-1:0]    prev_cs_q;
  logic [lcef_pkg::LevelW-1:0] level_q;
  logic [lcef_pkg::LevelW-1:0] level_d;

  // working registers
  logic [lcef_pkg::PosW-1:0]   pos_q;
  logic [lcef_pkg::MagW-1:0]   mag_q;
  logic [31:0]                 g_prod_q;
  logic [48:0]                 d_prod_q;
  logic [63:0]                 cs_prod_q;
  logic [lcef_pkg::CsW-1:0]    end_cs_q;
  logic [31:0]                 pct_prod_q;
  logic [31:0]                 quo_prod_q;

  logic [lcef_pkg::CsW-1:0]    start_cs_q;
  logic [lcef_pkg::CsW-1:0]    out_end_q;
  logic [lcef_pkg::PctW-1:0]   light_q;

  logic [lcef_pkg::PosW-1:0]   dt;
  logic [23:0]                 g_raw;
  logic [23:0]                 g_gate;
  logic [23:0]                 decayed;
  logic [23:0]                 peak;
  logic [14:0]                 pct_hi;

  assign dt     = pos_q - prev_time_q;
  assign g_raw  = g_prod_q[31:8];
  assign g_gate = (g_raw < {7'd0, min_q}) ? 24'd0 : g_raw;
  assign decayed = (d_prod_q >= {32'd0, level_q}) ? 24'd0
                 : {7'd0, level_q - d_prod_q[lcef_pkg::LevelW-1:0]};
  assign peak   = (g_gate > decayed) ? g_gate : decayed;
  assign level_d = (peak > {7'd0, lcef_pkg::LEVEL_ONE}) ? lcef_pkg::LEVEL_ONE
                 : peak[lcef_pkg::LevelW-1:0];
  assign pct_hi = pct_prod_q[30:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= lcef_pkg::GAIN_RESET;
      min_q       <= lcef_pkg::MIN_RESET;
      decay_q     <= lcef_pkg::DECAY_RESET;
      scale_q     <= lcef_pkg::SCALE_RESET;
      have_prev_q <= 1'b0;
      prev_time_q <= '0;
      prev_mag_q  <= '0;
      prev_cs_q   <= '0;
      level_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lcef_pkg::CFG_GAIN:      gain_q  <= cfg_data_i[lcef_pkg::GainW-1:0];
          lcef_pkg::CFG_MIN_LEVEL: min_q   <= cfg_data_i;
          lcef_pkg::CFG_DECAY:     decay_q <= cfg_data_i;
          lcef_pkg::CFG_VOLTAGE:   scale_q <= 15'(cfg_data_i[lcef_pkg::VoltW-1:0])
                                              * 15'(lcef_pkg::PERCENT);
          default: ;
        endcase
      end
      if (cmd_i.lvl && have_prev_q) begin
        level_q <= level_d;
      end
      if (cmd_i.fin) begin
        have_prev_q <= 1'b1;
        prev_time_q <= pos_q;
        prev_mag_q  <= mag_q;
        prev_cs_q   <= end_cs_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_q <= position_ms_i;
      mag_q <= magnitude_i;
    end
    if (cmd_i.mul) begin
      g_prod_q  <= 32'(prev_mag_q) * 32'(gain_q);
      d_prod_q  <= 49'(dt) * 49'(decay_q);
      cs_prod_q <= 64'(pos_q) * 64'(lcef_pkg::CS_RECIP);
    end
    if (cmd_i.lvl) begin
      end_cs_q <= cs_prod_q[lcef_pkg::CsShift +: lcef_pkg::CsW];
    end
    if (cmd_i.pct) begin
      pct_prod_q <= 32'(level_q) * 32'(scale_q);
    end
    if (cmd_i.quo) begin
      quo_prod_q <= 32'(pct_hi) * 32'(lcef_pkg::VOLT_RECIP);
    end
    if (cmd_i.fin) begin
      start_cs_q <= have_prev_q ? prev_cs_q : lcef_pkg::CsW'(1);
      out_end_q  <= end_cs_q;
      light_q    <= have_prev_q ? quo_prod_q[lcef_pkg::VoltShift +: lcef_pkg::PctW]
                                : '0;
    end
  end

  assign start_cs_o    = start_cs_q;
  assign end_cs_o      = out_end_q;
  assign light_level_o = light_q;

endmodule

`default_nettype wire
